### src/ptps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority tone pattern sequencer package
// Shared types, event and status codes, and the tone pattern table.
// ----------------------------------------------------------------------------
package ptps_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int NOW_W         = 32;
    localparam int FREQ_W        = 12;
    localparam int DUR_W         = 8;

    localparam logic [1:0] KIND_RING   = 2'd0;
    localparam logic [1:0] KIND_UPDATE = 2'd1;
    localparam logic [1:0] KIND_STOP   = 2'd2;

    localparam logic [1:0] TONE_KEYPRESS = 2'd0;
    localparam logic [1:0] TONE_GRANTED  = 2'd1;
    localparam logic [1:0] TONE_ERROR    = 2'd2;
    localparam logic [1:0] TONE_INVALID  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_FAIL    = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic apply;
        logic ring;
        logic abort;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic kind_ring;
        logic kind_update;
        logic kind_stop;
        logic tone_bad;
        logic step_more;
        logic out_free;
    } t_stat;

    function automatic logic [FREQ_W-1:0] rom_freq(input logic [1:0] pat,
                                                   input logic [1:0] ph);
        logic [FREQ_W-1:0] f;
        f = '0;
        unique case ({pat, ph})
            {TONE_KEYPRESS, 2'd0}: f = 12'd2600;
            {TONE_GRANTED, 2'd0}:  f = 12'd2000;
            {TONE_GRANTED, 2'd2}:  f = 12'd3000;
            {TONE_ERROR, 2'd0}:    f = 12'd2600;
            {TONE_ERROR, 2'd2}:    f = 12'd1800;
            default:               f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [DUR_W-1:0] rom_dur(input logic [1:0] pat,
                                                 input logic [1:0] ph);
        logic [DUR_W-1:0] d;
        d = 8'd1;
        unique case ({pat, ph})
            {TONE_KEYPRESS, 2'd0}: d = 8'd40;
            {TONE_GRANTED, 2'd0}:  d = 8'd80;
            {TONE_GRANTED, 2'd1}:  d = 8'd40;
            {TONE_GRANTED, 2'd2}:  d = 8'd140;
            {TONE_ERROR, 2'd0}:    d = 8'd120;
            {TONE_ERROR, 2'd1}:    d = 8'd50;
            {TONE_ERROR, 2'd2}:    d = 8'd220;
            default:               d = 8'd1;
        endcase
        return d;
    endfunction

    function automatic logic rom_on(input logic [1:0] pat, input logic [1:0] ph);
        logic o;
        o = 1'b0;
        unique case ({pat, ph})
            {TONE_KEYPRESS, 2'd0}: o = 1'b1;
            {TONE_GRANTED, 2'd0}:  o = 1'b1;
            {TONE_GRANTED, 2'd2}:  o = 1'b1;
            {TONE_ERROR, 2'd0}:    o = 1'b1;
            {TONE_ERROR, 2'd2}:    o = 1'b1;
            default:               o = 1'b0;
        endcase
        return o;
    endfunction

    function automatic logic [1:0] tone_len(input logic [1:0] pat);
        logic [1:0] n;
        n = 2'd0;
        unique case (pat)
            TONE_KEYPRESS: n = 2'd1;
            TONE_GRANTED:  n = 2'd3;
            TONE_ERROR:    n = 2'd3;
            default:       n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic tone_prio(input logic [1:0] pat);
        return (pat == TONE_GRANTED) || (pat == TONE_ERROR);
    endfunction

endpackage

### src/ptps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority tone pattern sequencer channel interfaces
// Event input channel and result output channel with valid and ready.
// ----------------------------------------------------------------------------
interface ptps_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [1:0]                  ringtone;
    logic [ptps_pkg::NOW_W-1:0]  now_ms;

    modport source (output valid, output kind, output ringtone, output now_ms,
                    input ready);
    modport sink (input valid, input kind, input ringtone, input now_ms,
                  output ready);
endinterface

interface ptps_out_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic                        tone_on;
    logic [ptps_pkg::FREQ_W-1:0] tone_freq_hz;
    logic                        busy_res;
    logic [1:0]                  playing_pattern;
    logic [1:0]                  playing_phase;

    modport source (output valid, output status, output tone_on,
                    output tone_freq_hz, output busy_res, output playing_pattern,
                    output playing_phase, input ready);
    modport sink (input valid, input status, input tone_on, input tone_freq_hz,
                  input busy_res, input playing_pattern, input playing_phase,
                  output ready);
endinterface

### src/ptps_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority tone pattern sequencer controller
// Steps one event through decode, phase skipping, ring start and output.
// ----------------------------------------------------------------------------
module ptps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ptps_pkg::t_stat i_stat,
    output ptps_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_UPD    = 3'd2;
    localparam logic [2:0] S_RING   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if ((i_stat.kind_ring && !i_stat.tone_bad) || i_stat.kind_update) begin
                    n_state = S_UPD;
                end else begin
                    o_cmd.abort = i_stat.kind_stop;
                    n_state     = S_DONE;
                end
            end
            S_UPD: begin
                if (i_stat.step_more) begin
                    o_cmd.step = 1'b1;
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = i_stat.kind_ring ? S_RING : S_DONE;
                end
            end
            S_RING: begin
                o_cmd.ring = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/ptps_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority tone pattern sequencer datapath
// Pattern state, phase timeline, buzzer drive and the result register.
// ----------------------------------------------------------------------------
module ptps_dp #(
    parameter int TIME_BITS = ptps_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_kind,
    input  logic [1:0]                  i_ringtone,
    input  logic [ptps_pkg::NOW_W-1:0]  i_now_ms,
    input  logic                        i_out_ready,
    input  ptps_pkg::t_cmd              i_cmd,
    output ptps_pkg::t_stat             o_stat,
    output logic                        o_out_valid,
    output logic [1:0]                  o_status,
    output logic                        o_tone_on,
    output logic [ptps_pkg::FREQ_W-1:0] o_tone_freq_hz,
    output logic                        o_busy_res,
    output logic [1:0]                  o_playing_pattern,
    output logic [1:0]                  o_playing_phase
);

    logic [TIME_BITS-1:0]        w_now;
    logic [1:0]                  r_kind;
    logic [1:0]                  r_tone;
    logic [TIME_BITS-1:0]        r_now;
    logic [1:0]                  r_status;
    logic                        r_moved;

    logic                        r_active;
    logic [1:0]                  r_pid;
    logic [1:0]                  r_phase;
    logic [TIME_BITS-1:0]        r_start;
    logic                        r_drive_on;
    logic [ptps_pkg::FREQ_W-1:0] r_drive_freq;

    logic [TIME_BITS-1:0]        w_elapsed;
    logic [ptps_pkg::DUR_W-1:0]  w_dur;
    logic [1:0]                  w_len;
    logic [2:0]                  w_next_phase;
    logic                        w_last;
    logic                        w_ignore;

    generate
        if (TIME_BITS >= ptps_pkg::NOW_W) begin : g_now_ext
            assign w_now = TIME_BITS'(i_now_ms);
        end else begin : g_now_cut
            assign w_now = i_now_ms[TIME_BITS-1:0];
        end
    endgenerate

    assign w_dur        = ptps_pkg::rom_dur(r_pid, r_phase);
    assign w_len        = ptps_pkg::tone_len(r_pid);
    assign w_elapsed    = r_now - r_start;
    assign w_next_phase = {1'b0, r_phase} + 3'd1;
    assign w_last       = w_next_phase >= {1'b0, w_len};
    assign w_ignore     = r_active &&
                          (ptps_pkg::tone_prio(r_tone) < ptps_pkg::tone_prio(r_pid));

    always_comb begin
        o_stat.kind_ring   = r_kind == ptps_pkg::KIND_RING;
        o_stat.kind_update = r_kind == ptps_pkg::KIND_UPDATE;
        o_stat.kind_stop   = r_kind == ptps_pkg::KIND_STOP;
        o_stat.tone_bad    = r_tone == ptps_pkg::TONE_INVALID;
        o_stat.step_more   = r_active && (r_phase < w_len) &&
                             (w_elapsed >= TIME_BITS'(w_dur));
        o_stat.out_free    = !o_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_tone <= i_ringtone;
            r_now  <= w_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_pid        <= '0;
            r_phase      <= '0;
            r_start      <= '0;
            r_drive_on   <= 1'b0;
            r_drive_freq <= '0;
            r_moved      <= 1'b0;
            r_status     <= ptps_pkg::ST_OK;
        end else begin
            if (i_cmd.load) begin
                r_moved  <= 1'b0;
                r_status <= ((i_kind == ptps_pkg::KIND_RING) &&
                             (i_ringtone == ptps_pkg::TONE_INVALID)) ?
                            ptps_pkg::ST_FAIL : ptps_pkg::ST_OK;
            end
            if (i_cmd.abort || (i_cmd.step && w_last)) begin
                r_active   <= 1'b0;
                r_pid      <= '0;
                r_phase    <= '0;
                r_start    <= '0;
                r_drive_on <= 1'b0;
                r_moved    <= 1'b0;
            end else if (i_cmd.step) begin
                r_phase <= w_next_phase[1:0];
                r_start <= r_start + TIME_BITS'(w_dur);
                r_moved <= 1'b1;
            end
            if (i_cmd.apply && r_moved) begin
                r_drive_on <= ptps_pkg::rom_on(r_pid, r_phase);
                if (ptps_pkg::rom_on(r_pid, r_phase)) begin
                    r_drive_freq <= ptps_pkg::rom_freq(r_pid, r_phase);
                end
            end
            if (i_cmd.ring) begin
                if (w_ignore) begin
                    r_status <= ptps_pkg::ST_IGNORED;
                end else begin
                    r_active     <= 1'b1;
                    r_pid        <= r_tone;
                    r_phase      <= '0;
                    r_start      <= r_now;
                    r_drive_on   <= ptps_pkg::rom_on(r_tone, 2'd0);
                    if (ptps_pkg::rom_on(r_tone, 2'd0)) begin
                        r_drive_freq <= ptps_pkg::rom_freq(r_tone, 2'd0);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status          <= r_status;
            o_tone_on         <= r_drive_on;
            o_tone_freq_hz    <= r_drive_freq;
            o_busy_res        <= r_active;
            o_playing_pattern <= r_active ? r_pid : 2'd0;
            o_playing_phase   <= r_active ? r_phase : 2'd0;
        end
    end

endmodule

### src/priority_tone_pattern_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority tone pattern sequencer
// Buzzer pattern sequencer with prioritized ring, update and stop events.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// i_in      sink       kind, ringtone, now_ms
// o_out     source     status, tone_on, tone_freq_hz, busy_res, pattern, phase
//
// One event is processed at a time: accept, decode, one step per expired phase
// skipped by the shared elapsed-time compare (up to three), one closing step,
// a ring step for ring events, and the output load. Stop and invalid rings go
// from decode straight to the output load.
// Reset is synchronous and active low and leaves the sequencer idle.
// A stalled result holds the controller before the output load.
// ----------------------------------------------------------------------------
module priority_tone_pattern_sequencer #(
    parameter int TIME_BITS = ptps_pkg::TIME_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ptps_in_if.sink    i_in,
    ptps_out_if.source o_out
);

    ptps_pkg::t_cmd  w_cmd;
    ptps_pkg::t_stat w_stat;

    ptps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    ptps_dp #(
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_kind            (i_in.kind),
        .i_ringtone        (i_in.ringtone),
        .i_now_ms          (i_in.now_ms),
        .i_out_ready       (o_out.ready),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_out_valid       (o_out.valid),
        .o_status          (o_out.status),
        .o_tone_on         (o_out.tone_on),
        .o_tone_freq_hz    (o_out.tone_freq_hz),
        .o_busy_res        (o_out.busy_res),
        .o_playing_pattern (o_out.playing_pattern),
        .o_playing_phase   (o_out.playing_phase)
    );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority tone pattern sequencer testbench
// Sends ring, update and stop events with timestamps and checks each result
// against a predictor of the tone pattern timeline.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]                  status;
        logic                        tone_on;
        logic [ptps_pkg::FREQ_W-1:0] tone_freq_hz;
        logic                        busy_res;
        logic [1:0]                  playing_pattern;
        logic [1:0]                  playing_phase;
    } t_tone_result;

    typedef struct packed {
        logic [ptps_pkg::FREQ_W-1:0] freq;
        logic [31:0]                 dur;
        logic                        on;
    } t_tone_phase;

    logic i_clk;
    logic i_rst_n;

    ptps_in_if  in_ch();
    ptps_out_if out_ch();

    priority_tone_pattern_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_tone_result expected_results[$];
    int           mismatch_count;
    logic         tx_quiet;
    logic         rx_quiet;
    int           rx_hold_left;
    int           rx_stall_left;
    logic [31:0]  now_cursor;

    logic                        seq_active;
    logic [1:0]                  seq_pattern;
    logic [1:0]                  seq_phase;
    logic [31:0]                 seq_start_ms;
    logic                        seq_drive_on;
    logic [ptps_pkg::FREQ_W-1:0] seq_drive_freq;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_tone_phase phase_entry(input logic [1:0] pat, input logic [1:0] ph);
        t_tone_phase e;
        e = '{freq: '0, dur: 32'd1, on: 1'b0};
        case (pat)
            ptps_pkg::TONE_KEYPRESS: begin
                if (ph == 2'd0) e = '{freq: 12'd2600, dur: 32'd40, on: 1'b1};
            end
            ptps_pkg::TONE_GRANTED: begin
                case (ph)
                    2'd0: e = '{freq: 12'd2000, dur: 32'd80, on: 1'b1};
                    2'd1: e = '{freq: 12'd0, dur: 32'd40, on: 1'b0};
                    2'd2: e = '{freq: 12'd3000, dur: 32'd140, on: 1'b1};
                    default: e = '{freq: 12'd0, dur: 32'd1, on: 1'b0};
                endcase
            end
            ptps_pkg::TONE_ERROR: begin
                case (ph)
                    2'd0: e = '{freq: 12'd2600, dur: 32'd120, on: 1'b1};
                    2'd1: e = '{freq: 12'd0, dur: 32'd50, on: 1'b0};
                    2'd2: e = '{freq: 12'd1800, dur: 32'd220, on: 1'b1};
                    default: e = '{freq: 12'd0, dur: 32'd1, on: 1'b0};
                endcase
            end
            default: e = '{freq: 12'd0, dur: 32'd1, on: 1'b0};
        endcase
        return e;
    endfunction

    function automatic logic [1:0] pattern_length(input logic [1:0] pat);
        if (pat == ptps_pkg::TONE_KEYPRESS) return 2'd1;
        if (pat == ptps_pkg::TONE_GRANTED || pat == ptps_pkg::TONE_ERROR) return 2'd3;
        return 2'd0;
    endfunction

    function automatic logic is_high_priority(input logic [1:0] pat);
        return (pat == ptps_pkg::TONE_GRANTED) || (pat == ptps_pkg::TONE_ERROR);
    endfunction

    function automatic void silence_buzzer();
        seq_drive_on = 1'b0;
        seq_active   = 1'b0;
        seq_pattern  = '0;
        seq_phase    = '0;
        seq_start_ms = '0;
    endfunction

    function automatic void drive_phase();
        t_tone_phase e;
        e = phase_entry(seq_pattern, seq_phase);
        if (e.on) begin
            seq_drive_freq = e.freq;
            seq_drive_on   = 1'b1;
        end else begin
            seq_drive_on = 1'b0;
        end
    endfunction

    function automatic void advance_timeline(input logic [31:0] now);
        t_tone_phase e;
        logic [1:0]  len;
        logic [31:0] elapsed;
        logic        moved;
        logic        done;
        moved = 1'b0;
        done  = 1'b0;
        if (!seq_active) return;
        len = pattern_length(seq_pattern);
        while (!done && seq_phase < len) begin
            e = phase_entry(seq_pattern, seq_phase);
            elapsed = now - seq_start_ms;
            if (elapsed < e.dur) begin
                done = 1'b1;
            end else begin
                seq_start_ms = seq_start_ms + e.dur;
                seq_phase    = seq_phase + 2'd1;
                moved        = 1'b1;
                if (seq_phase >= len) begin
                    silence_buzzer();
                    return;
                end
            end
        end
        if (moved) drive_phase();
    endfunction

    function automatic t_tone_result predict_tone_event(input logic [1:0] kind,
                                                        input logic [1:0] tone,
                                                        input logic [31:0] now);
        t_tone_result r;
        r.status = ptps_pkg::ST_OK;
        case (kind)
            ptps_pkg::KIND_RING: begin
                if (tone == ptps_pkg::TONE_INVALID) begin
                    r.status = ptps_pkg::ST_FAIL;
                end else begin
                    advance_timeline(now);
                    if (seq_active && !is_high_priority(tone) &&
                        is_high_priority(seq_pattern)) begin
                        r.status = ptps_pkg::ST_IGNORED;
                    end else begin
                        seq_active   = 1'b1;
                        seq_pattern  = tone;
                        seq_phase    = '0;
                        seq_start_ms = now;
                        drive_phase();
                    end
                end
            end
            ptps_pkg::KIND_UPDATE: advance_timeline(now);
            ptps_pkg::KIND_STOP:   silence_buzzer();
            default:     ;
        endcase
        r.tone_on         = seq_drive_on;
        r.tone_freq_hz    = seq_drive_freq;
        r.busy_res        = seq_active;
        r.playing_pattern = seq_active ? seq_pattern : 2'd0;
        r.playing_phase   = seq_active ? seq_phase : 2'd0;
        return r;
    endfunction

    function automatic int pick_gap(input logic quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] next_delta();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'd1;
            2, 3:    return 32'($urandom_range(35, 45));
            4, 5:    return 32'($urandom_range(75, 145));
            6, 7:    return 32'($urandom_range(0, 260));
            8:       return 32'($urandom_range(200, 700));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_event(input logic [1:0] kind, input logic [1:0] tone,
                              input logic [31:0] now);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.ringtone <= tone;
        in_ch.now_ms   <= now;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        expected_results.push_back(predict_tone_event(kind, tone, now));
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        out_ch.ready  = 1'b0;
        rx_stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                rx_hold_left = rx_hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (rx_stall_left > 0) begin
                rx_stall_left = rx_stall_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                rx_stall_left = pick_gap(rx_quiet);
                if (rx_stall_left > 0) begin
                    rx_stall_left = rx_stall_left - 1;
                    out_ch.ready <= 1'b0;
                end else begin
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_tone_result got;
        t_tone_result want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got.status          = out_ch.status;
            got.tone_on         = out_ch.tone_on;
            got.tone_freq_hz    = out_ch.tone_freq_hz;
            got.busy_res        = out_ch.busy_res;
            got.playing_pattern = out_ch.playing_pattern;
            got.playing_phase   = out_ch.playing_phase;
            if (expected_results.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with no pending event: %p", $realtime, got);
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status || got.tone_on !== want.tone_on ||
                    got.tone_freq_hz !== want.tone_freq_hz ||
                    got.busy_res !== want.busy_res ||
                    got.playing_pattern !== want.playing_pattern ||
                    got.playing_phase !== want.playing_phase) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: expected %p, got %p", $realtime, want, got);
                end
            end
        end
    end

    task automatic test_idle_events();
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'd0);
        send_event(ptps_pkg::KIND_STOP, ptps_pkg::TONE_ERROR, 32'hFFFF_FFFF);
        send_event(KIND_UNUSED, ptps_pkg::TONE_INVALID, 32'd1000);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_INVALID, 32'd1000);
    endtask

    task automatic test_keypress_pattern();
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_KEYPRESS, 32'd1000);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'd1039);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'd1040);
    endtask

    task automatic test_priority_rules();
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_GRANTED, 32'd2000);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_KEYPRESS, 32'd2010);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'd2080);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'd2120);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_INVALID, 32'd2130);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'd2260);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_ERROR, 32'd3000);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_GRANTED, 32'd3010);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_KEYPRESS, 32'd3011);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'd3500);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_KEYPRESS, 32'd4000);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_KEYPRESS, 32'd4020);
    endtask

    task automatic test_timer_wrap();
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_ERROR, 32'hFFFF_FFC0);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'h0000_0038);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'h0000_006A);
        send_event(ptps_pkg::KIND_STOP, ptps_pkg::TONE_KEYPRESS, 32'h0000_0070);
        send_event(ptps_pkg::KIND_RING, ptps_pkg::TONE_KEYPRESS, 32'hFFFF_FFFF);
        send_event(ptps_pkg::KIND_UPDATE, ptps_pkg::TONE_KEYPRESS, 32'h0000_0027);
    endtask

    task automatic run_random_events(input int count);
        int         sent;
        int         steps;
        logic [1:0] kind;
        logic [1:0] tone;
        logic [31:0] now;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                if ($urandom_range(0, 9) == 0)
                    now_cursor = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
                tone = ($urandom_range(0, 19) == 0) ? ptps_pkg::TONE_INVALID
                                                    : 2'($urandom_range(0, 2));
                send_event(ptps_pkg::KIND_RING, tone, now_cursor);
                sent++;
                steps = $urandom_range(1, 6);
                repeat (steps) begin
                    now_cursor = now_cursor + next_delta();
                    case ($urandom_range(0, 9))
                        7, 8:    kind = ptps_pkg::KIND_RING;
                        9:       kind = ptps_pkg::KIND_STOP;
                        default: kind = ptps_pkg::KIND_UPDATE;
                    endcase
                    tone = (kind == ptps_pkg::KIND_RING) ? 2'($urandom_range(0, 2))
                                                         : 2'($urandom);
                    send_event(kind, tone, now_cursor);
                    sent++;
                end
            end else begin
                kind = 2'($urandom);
                tone = 2'($urandom);
                now  = $urandom_range(0, 1) ? $urandom : now_cursor;
                send_event(kind, tone, now);
                if (kind != KIND_UNUSED) sent++;
            end
        end
    endtask

    task automatic test_result_backpressure();
        tx_quiet     = 1'b1;
        rx_hold_left = 250;
        run_random_events(40);
        while (rx_hold_left > 0) @(negedge i_clk);
        wait_for_drain();
        tx_quiet = 1'b0;
    endtask

    task automatic test_sender_pause();
        run_random_events(20);
        wait_for_drain();
        run_random_events(20);
    endtask

    task automatic test_random_timeline();
        run_random_events(500);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_random_events(150);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        run_random_events(500);
    endtask

    initial begin
        mismatch_count = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        rx_hold_left   = 0;
        now_cursor     = $urandom;
        seq_active     = 1'b0;
        seq_pattern    = '0;
        seq_phase      = '0;
        seq_start_ms   = '0;
        seq_drive_on   = 1'b0;
        seq_drive_freq = '0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.kind     = ptps_pkg::KIND_RING;
        in_ch.ringtone = ptps_pkg::TONE_KEYPRESS;
        in_ch.now_ms   = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_events();
        test_keypress_pattern();
        test_priority_rules();
        test_timer_wrap();
        test_result_backpressure();
        test_sender_pause();
        test_random_timeline();

        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
